// ----- src/spi_rfm_pkg.sv -----
// Shared types, codes and constants of the SPI register frame master.
package spi_rfm_pkg;

    localparam int unsigned CFG_WIDTH       = 8;
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned FRAME_BITS      = 32;
    localparam int unsigned READ_BITS       = 8;
    localparam int unsigned BITS_WIDTH      = 6;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } command_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_HIGH_TICKS   = 2'd0,
        CFG_READ_OPCODE  = 2'd1,
        CFG_WRITE_OPCODE = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    localparam logic [CFG_WIDTH-1:0] HIGH_TICKS_RESET   = 8'd10;
    localparam logic [CFG_WIDTH-1:0] READ_OPCODE_RESET  = 8'h0F;
    localparam logic [CFG_WIDTH-1:0] WRITE_OPCODE_RESET = 8'hF0;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  write_value;
        logic        miso;
    } spi_rfm_in_t;

    typedef struct packed {
        logic       cs_n;
        logic       sclk;
        logic       mosi;
        logic       busy_res;
        logic       done_res;
        logic       rejected;
        logic [7:0] read_data;
    } spi_rfm_out_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] high_ticks;
        logic [CFG_WIDTH-1:0] read_opcode;
        logic [CFG_WIDTH-1:0] write_opcode;
    } spi_rfm_cfg_t;

endpackage

// ----- src/spi_rfm_core.sv -----
// Frame sequencer: holds the pin state and computes one result per item.
module spi_rfm_core
    import spi_rfm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_wdata,
    input  logic                       step_en,
    input  spi_rfm_in_t                step_item,
    output spi_rfm_out_t               step_result
);

    spi_rfm_cfg_t cfg_reg;

    logic [31:0]           frame_shift_reg, frame_shift_next;
    logic [BITS_WIDTH-1:0] bits_left_reg, bits_left_next;
    logic [7:0]            high_count_reg, high_count_next;
    logic                  is_read_reg, is_read_next;
    logic [7:0]            read_shift_reg, read_shift_next;
    logic                  sclk_reg, sclk_next;
    logic                  mosi_reg, mosi_next;
    logic                  cs_reg, cs_next;

    logic                  busy;
    logic                  start;
    logic                  done;
    logic [7:0]            rdata;
    logic [BITS_WIDTH-1:0] bits_dec;
    logic                  in_read_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.high_ticks   <= HIGH_TICKS_RESET;
            cfg_reg.read_opcode  <= READ_OPCODE_RESET;
            cfg_reg.write_opcode <= WRITE_OPCODE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_HIGH_TICKS:   cfg_reg.high_ticks   <= cfg_wdata;
                CFG_READ_OPCODE:  cfg_reg.read_opcode  <= cfg_wdata;
                CFG_WRITE_OPCODE: cfg_reg.write_opcode <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign busy         = !cs_reg;
    assign start        = (command_t'(step_item.command) == CMD_READ) ||
                          (command_t'(step_item.command) == CMD_WRITE);
    assign bits_dec     = bits_left_reg - BITS_WIDTH'(1);
    assign in_read_byte = is_read_reg && (bits_left_reg <= BITS_WIDTH'(READ_BITS));

    always_comb begin
        frame_shift_next = frame_shift_reg;
        bits_left_next   = bits_left_reg;
        high_count_next  = high_count_reg;
        is_read_next     = is_read_reg;
        read_shift_next  = read_shift_reg;
        sclk_next        = sclk_reg;
        mosi_next        = mosi_reg;
        cs_next          = cs_reg;
        done             = 1'b0;
        rdata            = '0;

        if (start && !busy) begin
            is_read_next = (command_t'(step_item.command) == CMD_READ);
            if (command_t'(step_item.command) == CMD_READ) begin
                frame_shift_next = {cfg_reg.read_opcode, step_item.address, 8'd0};
            end else begin
                frame_shift_next = {cfg_reg.write_opcode, step_item.address,
                                    step_item.write_value};
            end
            bits_left_next  = BITS_WIDTH'(FRAME_BITS);
            read_shift_next = '0;
            high_count_next = '0;
            sclk_next       = 1'b0;
            cs_next         = 1'b0;
        end else if (busy) begin
            if (!sclk_reg) begin
                if (bits_left_reg == '0) begin
                    // Cannot happen in a running frame; close it cleanly.
                    cs_next = 1'b1;
                    done    = 1'b1;
                    rdata   = is_read_reg ? read_shift_reg : 8'd0;
                end else begin
                    // Rising edge: MOSI holds during the read byte.
                    if (!in_read_byte) begin
                        mosi_next = frame_shift_reg[31];
                    end
                    frame_shift_next = {frame_shift_reg[30:0], 1'b0};
                    sclk_next        = 1'b1;
                    high_count_next  = (cfg_reg.high_ticks == '0) ? 8'd0 :
                                       cfg_reg.high_ticks - 8'd1;
                end
            end else if (high_count_reg != '0) begin
                high_count_next = high_count_reg - 8'd1;
            end else begin
                // Falling edge: sample MISO in the read byte.
                if (in_read_byte) begin
                    read_shift_next = {read_shift_reg[6:0], step_item.miso};
                end
                sclk_next      = 1'b0;
                bits_left_next = bits_dec;
                if (bits_dec == '0) begin
                    cs_next = 1'b1;
                    done    = 1'b1;
                    rdata   = is_read_reg ? read_shift_next : 8'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_shift_reg <= '0;
            bits_left_reg   <= '0;
            high_count_reg  <= '0;
            is_read_reg     <= 1'b0;
            read_shift_reg  <= '0;
            sclk_reg        <= 1'b0;
            mosi_reg        <= 1'b0;
            cs_reg          <= 1'b1;
        end else if (step_en) begin
            frame_shift_reg <= frame_shift_next;
            bits_left_reg   <= bits_left_next;
            high_count_reg  <= high_count_next;
            is_read_reg     <= is_read_next;
            read_shift_reg  <= read_shift_next;
            sclk_reg        <= sclk_next;
            mosi_reg        <= mosi_next;
            cs_reg          <= cs_next;
        end
    end

    always_comb begin
        step_result.cs_n      = cs_next;
        step_result.sclk      = sclk_next;
        step_result.mosi      = mosi_next;
        step_result.busy_res  = !cs_next;
        step_result.done_res  = done;
        step_result.rejected  = start && busy;
        step_result.read_data = rdata;
    end

endmodule

// ----- src/spi_rfm_outbuf.sv -----
// Result register with a skid stage so items keep flowing under back-pressure until the skid stage is full.
module spi_rfm_outbuf
    import spi_rfm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  spi_rfm_out_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output spi_rfm_out_t out_data
);

    logic         main_valid_reg;
    spi_rfm_out_t main_data_reg;
    logic         skid_valid_reg;
    spi_rfm_out_t skid_data_reg;
    logic         pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign pop       = main_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (!main_valid_reg || pop) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (in_valid) begin
            if (!main_valid_reg || pop) begin
                main_data_reg <= in_data;
            end else begin
                skid_data_reg <= in_data;
            end
        end
    end

endmodule

// ----- src/spi_register_frame_master.sv -----
// A result is registered in the output register, or in the skid entry when that register holds a stalled result.
// Throughput: one item per cycle while s_ready is high; the frame sequencer updates in the accepting cycle.
// A full skid stage behind the output register is the only thing that drops s_ready.
// Reset (aresetn low, synchronous) deselects the chip, stops SCLK, empties the output
// stages and restores the configuration registers to their power-on values.
module spi_register_frame_master
    import spi_rfm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  spi_rfm_in_t                s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output spi_rfm_out_t               m_data
);

    // Every accepted item is one tick of pin sequencing. The sequencer state
    // advances only on acceptance, so the result of an item always reflects
    // the items before it, regardless of how the output side stalls.
    logic         step_en;
    spi_rfm_out_t step_result;

    assign step_en = s_valid && s_ready;

    // Frame sequencer: chip select, SCLK high-time counter, shift registers.
    spi_rfm_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .step_en     (step_en),
        .step_item   (s_data),
        .step_result (step_result)
    );

    // Output register plus skid entry. Taking an item while a result waits
    // is possible because the skid entry catches it; s_ready falls only
    // when both entries are full.
    spi_rfm_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (step_en),
        .in_ready  (s_ready),
        .in_data   (step_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ----- src/spi_rfm_checker.sv -----
// Port-level checks of the SPI register frame master and their binding.
module spi_rfm_assertions
    import spi_rfm_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_valid,
    input logic         m_ready,
    input spi_rfm_out_t m_data
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A finished frame always leaves the chip deselected.
    a_done_cs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> m_data.cs_n && !m_data.busy_res && !m_data.sclk)
        else $error("done without chip select released");

    // Read data is only carried by a done result.
    a_rdata: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.done_res |-> m_data.read_data == 8'd0)
        else $error("read data outside a done result");

    // Busy is the inverse of chip select, and SCLK only toggles while busy.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.busy_res != m_data.cs_n) && (m_data.cs_n ? !m_data.sclk : 1'b1))
        else $error("busy and chip select disagree");

endmodule

bind spi_register_frame_master spi_rfm_assertions u_spi_rfm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
